FILE: sv/lrukv_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lrukv_pkg;

  localparam int unsigned DEFAULT_ENTRIES = 16;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;
  localparam logic signed [VAL_W-1:0] PUT_VALUE = 32'sd0;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] put_value;
  } req_t;

  typedef struct packed {
    logic hit;
    logic signed [VAL_W-1:0] read_value;
  } resp_t;

endpackage

FILE: sv/lrukv_in_if.sv
// Request channel: valid/ready with command, key and value.
interface lrukv_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [31:0] lookup_key;
  logic signed [31:0] put_value;

  modport source (output valid, output cmd, output lookup_key, output put_value, input ready);
  modport sink (input valid, input cmd, input lookup_key, input put_value, output ready);
endinterface

FILE: sv/lrukv_out_if.sv
// Result channel: valid/ready with hit flag and read value.
interface lrukv_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic signed [31:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink (input valid, input hit, input read_value, output ready);
endinterface

FILE: sv/lru_key_value_cache.sv
// Top level of the LRU key-value cache.
//
// Channels: in_ch carries get/put requests (cmd, lookup_key, put_value);
// out_ch returns one beat per request (hit, read_value). Both use
// valid/ready and a beat moves when both are high at a clock edge.
// cfg_we/cfg_wdata write the capacity register; any write empties the store.
// Write it only with no request in flight.
//
// Flow: a request beat lands in an input register, where it is matched
// against all entries in parallel; once the output register is free or
// draining, the entry state is updated and the result lands in the
// output register. Throughput: one beat per cycle while out_ch does not stall,
// set by the combinational match and age-rank update across the entry array.
//
// Reset: store empty, capacity 16. When out_ch stalls, the output register
// holds its beat, one further request waits in the input register, and
// in_ch.ready drops until the output drains.
module lru_key_value_cache import lrukv_pkg::*; #(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  lrukv_in_if.sink         in_ch,
  lrukv_out_if.source      out_ch
);

  req_t  req_r;
  logic  req_valid_r;
  resp_t resp;
  resp_t out_r;
  logic  out_valid_r;
  logic  go;

  assign go          = req_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !req_valid_r || go;

  lrukv_store #(
    .ENTRIES(ENTRIES)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .go        (go),
    .req       (req_r),
    .resp      (resp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        req_valid_r <= in_ch.valid;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_r.cmd        <= cmd_t'(in_ch.cmd);
      req_r.lookup_key <= in_ch.lookup_key;
      req_r.put_value  <= in_ch.put_value;
    end
    if (go) begin
      out_r <= resp;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_r.hit;
  assign out_ch.read_value = out_r.read_value;

  a_put_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (req_r.cmd == CMD_PUT)) |=> out_r.read_value == PUT_VALUE)
    else $error("put result not zero");

  a_miss_reads_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (req_r.cmd == CMD_GET) && !resp.hit) |=> out_r.read_value == MISS_VALUE)
    else $error("get miss did not return minus one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !go)
    else $error("output beat overwritten while stalled");

endmodule

FILE: sv/lrukv_store.sv
// Entry array: parallel key match, age-rank update, insert and eviction.
module lrukv_store import lrukv_pkg::*; #(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             go,
  input  req_t             req,
  output resp_t            resp
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [KEY_W-1:0]    key_r   [ENTRIES];
  logic [KEY_W-1:0]    key_nxt [ENTRIES];
  logic [VAL_W-1:0]    value_r   [ENTRIES];
  logic [VAL_W-1:0]    value_nxt [ENTRIES];
  logic [IDX_W-1:0]    rank_r   [ENTRIES];
  logic [IDX_W-1:0]    rank_nxt [ENTRIES];
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [CFG_W-1:0]    cap_r, cap_nxt;

  logic [ENTRIES-1:0]  match;
  logic                hit;
  logic [IDX_W-1:0]    found_idx;
  logic [IDX_W-1:0]    found_rank;
  logic [VAL_W-1:0]    found_value;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    lru_idx;
  logic [CNT_W-1:0]    occ_m1;
  logic                full;
  logic [IDX_W-1:0]    slot;

  // lookup
  always_comb begin
    found_idx   = '0;
    found_rank  = '0;
    found_value = '0;
    lru_idx     = '0;
    free_idx    = '0;
    occ_m1      = occ_r - 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == req.lookup_key);
      if (match[i]) begin
        found_idx   = found_idx | IDX_W'(i);
        found_rank  = found_rank | rank_r[i];
        found_value = found_value | value_r[i];
      end
      if (valid_r[i] && (rank_r[i] == occ_m1[IDX_W-1:0])) begin
        lru_idx = lru_idx | IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    hit  = |match;
    full = (CMP_W'(occ_r) >= CMP_W'(cap_r)) || (occ_r == CNT_W'(ENTRIES));
    slot = full ? lru_idx : free_idx;
  end

  // next state
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    rank_nxt  = rank_r;
    occ_nxt   = occ_r;
    cap_nxt   = cap_r;
    if (cfg_we) begin
      valid_nxt = '0;
      occ_nxt   = '0;
      cap_nxt   = cfg_wdata;
    end else if (go) begin
      if (hit) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_r[j] && (rank_r[j] < found_rank)) begin
            rank_nxt[j] = rank_r[j] + 1'b1;
          end
        end
        rank_nxt[found_idx] = '0;
        if (req.cmd == CMD_PUT) begin
          value_nxt[found_idx] = req.put_value;
        end
      end else if ((req.cmd == CMD_PUT) && (cap_r != '0)) begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_r[j] && (IDX_W'(j) != slot)) begin
            rank_nxt[j] = rank_r[j] + 1'b1;
          end
        end
        valid_nxt[slot] = 1'b1;
        key_nxt[slot]   = req.lookup_key;
        value_nxt[slot] = req.put_value;
        rank_nxt[slot]  = '0;
        if (!full) begin
          occ_nxt = occ_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    resp.hit = hit;
    if (req.cmd == CMD_PUT) begin
      resp.read_value = PUT_VALUE;
    end else if (hit) begin
      resp.read_value = found_value;
    end else begin
      resp.read_value = MISS_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    rank_r  <= rank_nxt;
  end

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == occ_r)
    else $error("occupancy out of step with valid bits");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(ENTRIES))
    else $error("occupancy above entry count");

  a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key held in more than one entry");

  a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (valid_r == '0) && (occ_r == '0))
    else $error("capacity write did not empty the store");

  a_no_grow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !cfg_we && full) |=> occ_r == $past(occ_r))
    else $error("occupancy grew past capacity");

endmodule

FILE: tb/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key-value cache: random get/put traffic against a predictor.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
  import lrukv_pkg::*;

  localparam int ENT = DEFAULT_ENTRIES;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 104;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lrukv_in_if req_ch();
  lrukv_out_if rsp_ch();

  lru_key_value_cache dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(req_ch),
    .out_ch(rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted cache contents
  logic [CFG_W-1:0] cap_reg;
  logic ent_valid [ENT];
  logic [KEY_W-1:0] ent_key [ENT];
  logic [VAL_W-1:0] ent_val [ENT];
  logic [3:0] ent_rank [ENT];
  logic [4:0] occupancy;

  req_t req_queue [$];
  resp_t resp_expected [$];
  req_t cur_req;

  int err_count;
  int send_wait;
  int recv_wait;
  int hold_request;
  int hold_left;
  int stall_cycles;
  bit no_idle;

  function automatic void set_capacity(logic [CFG_W-1:0] v);
    cap_reg = v;
    for (int i = 0; i < ENT; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i] = '0;
      ent_val[i] = '0;
      ent_rank[i] = '0;
    end
    occupancy = '0;
  endfunction

  function automatic void make_recent(int idx);
    logic [3:0] r;
    r = ent_rank[idx];
    for (int j = 0; j < ENT; j++) begin
      if (ent_valid[j] && ent_rank[j] < r) ent_rank[j] = ent_rank[j] + 4'd1;
    end
    ent_rank[idx] = '0;
  endfunction

  function automatic resp_t cache_access(req_t rq);
    resp_t rs;
    int found;
    int slot;
    logic [4:0] eff;
    logic [3:0] oldest;
    found = -1;
    slot = -1;
    oldest = '0;
    for (int i = 0; i < ENT; i++) begin
      if (found < 0 && ent_valid[i] && ent_key[i] == rq.lookup_key) found = i;
    end
    rs.hit = (found >= 0);
    if (rq.cmd == CMD_GET) begin
      rs.read_value = (found >= 0) ? ent_val[found] : MISS_VALUE;
      if (found >= 0) make_recent(found);
      return rs;
    end
    rs.read_value = PUT_VALUE;
    if (found >= 0) begin
      ent_val[found] = rq.put_value;
      make_recent(found);
      return rs;
    end
    eff = (cap_reg > ENT) ? 5'(ENT) : cap_reg;
    if (eff == 0) return rs;
    if (occupancy >= eff) begin
      for (int i = 0; i < ENT; i++) begin
        if (ent_valid[i] && (slot < 0 || ent_rank[i] > oldest)) begin
          oldest = ent_rank[i];
          slot = i;
        end
      end
      if (slot < 0) return rs;
      ent_valid[slot] = 1'b0;
      occupancy = occupancy - 5'd1;
    end else begin
      for (int i = 0; i < ENT; i++) begin
        if (slot < 0 && !ent_valid[i]) slot = i;
      end
      if (slot < 0) return rs;
    end
    for (int i = 0; i < ENT; i++) begin
      if (ent_valid[i]) ent_rank[i] = ent_rank[i] + 4'd1;
    end
    ent_valid[slot] = 1'b1;
    ent_key[slot] = rq.lookup_key;
    ent_val[slot] = rq.put_value;
    ent_rank[slot] = '0;
    occupancy = occupancy + 5'd1;
    return rs;
  endfunction

  function automatic int draw_wait();
    if (no_idle) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    if (err_count <= 100) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        resp_expected.push_back(cache_access(cur_req));
        send_wait = draw_wait();
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          req_ch.valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          cur_req = req_queue.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.cmd <= cur_req.cmd;
          req_ch.lookup_key <= cur_req.lookup_key;
          req_ch.put_value <= cur_req.put_value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    resp_t exp_rs;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (resp_expected.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          exp_rs = resp_expected.pop_front();
          if (rsp_ch.hit !== exp_rs.hit)
            report_mismatch($sformatf("hit got %b exp %b", rsp_ch.hit, exp_rs.hit));
          if (rsp_ch.read_value !== exp_rs.read_value)
            report_mismatch($sformatf("read_value got %h exp %h",
                                      rsp_ch.read_value, exp_rs.read_value));
        end
        recv_wait = draw_wait();
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles == STALL_LIMIT) begin
      $display("lru_key_value_cache regression: fail");
      $finish;
    end
  end

  task automatic queue_req(cmd_t c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    req_queue.push_back('{cmd: c, lookup_key: k, put_value: v});
  endtask

  task automatic wait_drained();
    while (req_queue.size() != 0 || req_ch.valid || resp_expected.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_cap(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_capacity(v);
    @(negedge clk);
  endtask

  task automatic fill_random(int n, int pool_n);
    logic [KEY_W-1:0] key_pool [$];
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    int sel;
    key_pool.push_back(32'h8000_0000);
    key_pool.push_back(32'h7fff_ffff);
    for (int i = 0; i < pool_n; i++) key_pool.push_back($urandom);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      k = (sel == 0) ? $urandom : key_pool[$urandom_range(0, key_pool.size() - 1)];
      sel = $urandom_range(0, 15);
      case (sel)
        0: v = '0;
        1: v = '1;
        2: v = 32'h8000_0000;
        3: v = 32'h7fff_ffff;
        default: v = $urandom;
      endcase
      queue_req($urandom_range(0, 1) ? CMD_PUT : CMD_GET, k, v);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] caps [12];
    int eff;
    caps = '{5'd31, 5'd1, 5'd16, 5'd4, 5'd0, 5'd9, 5'd16, 5'd2, 5'd17, 5'd12, 5'd16, 5'd7};
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_GET;
    req_ch.lookup_key = '0;
    req_ch.put_value = '0;
    rsp_ch.ready = 1'b0;
    err_count = 0;
    hold_request = 0;
    no_idle = 1'b0;
    stall_cycles = 0;
    set_capacity(CAP_RESET);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset capacity: empty lookup, extreme keys and values, overwrite
    queue_req(CMD_GET, 32'h0000_0000, 32'h1234_5678);
    queue_req(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
    queue_req(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
    queue_req(CMD_PUT, 32'hffff_ffff, 32'h0000_0000);
    queue_req(CMD_PUT, 32'h0000_0000, 32'hffff_ffff);
    queue_req(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(CMD_GET, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(CMD_PUT, 32'h7fff_ffff, 32'h1234_5678);
    queue_req(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
    queue_req(CMD_GET, 32'h0000_0001, 32'h0000_0000);
    wait_drained();

    // rewriting the same capacity still empties the store
    write_cap(5'd16);
    queue_req(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    wait_drained();

    // two entries: eviction order follows recency
    write_cap(5'd2);
    queue_req(CMD_PUT, 32'd10, 32'd100);
    queue_req(CMD_PUT, 32'd20, 32'd200);
    queue_req(CMD_GET, 32'd10, 32'd0);
    queue_req(CMD_PUT, 32'd30, 32'd300);
    queue_req(CMD_GET, 32'd20, 32'd0);
    queue_req(CMD_GET, 32'd10, 32'd0);
    queue_req(CMD_PUT, 32'd40, 32'd400);
    queue_req(CMD_GET, 32'd30, 32'd0);
    queue_req(CMD_GET, 32'd10, 32'd0);
    wait_drained();

    // zero capacity: nothing is kept
    write_cap(5'd0);
    queue_req(CMD_PUT, 32'd5, 32'd55);
    queue_req(CMD_GET, 32'd5, 32'd0);
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      write_cap(caps[p]);
      eff = (caps[p] > ENT) ? ENT : caps[p];
      no_idle = (p == 2 || p == 5 || p == 8);
      if (p == 5) hold_request = 300;
      fill_random(PHASE_ITEMS, eff + 1 + $urandom_range(0, eff));
      wait_drained();
    end

    repeat (5) @(posedge clk);
    if (err_count == 0)
      $display("lru_key_value_cache regression: pass");
    else
      $display("lru_key_value_cache regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
sv/lrukv_pkg.sv
sv/lrukv_in_if.sv
sv/lrukv_out_if.sv
sv/lrukv_store.sv
sv/lru_key_value_cache.sv
tb/tb_lru_key_value_cache.sv
